>>> src/assert_macros.svh
// Assertion macros shared by the console writer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define TCW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("console writer check failed");

// Next-cycle implication, disabled while reset is held.
`define TCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("console writer check failed");

`endif

>>> src/tcw_pkg.sv
// Shared constants, codes and controller/datapath interface types of the console writer.
package tcw_pkg;

    // Default grid geometry
    localparam int DEF_COLUMNS  = 80;
    localparam int DEF_ROWS     = 25;
    localparam int DEF_TAB_STEP = 4;

    // Field widths
    localparam int CHAR_W     = 8;
    localparam int INDEX_W    = 11;
    localparam int OUT_COL_W  = 7;
    localparam int OUT_ROW_W  = 5;
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 24;

    // Action codes
    localparam logic ACTION_PUT  = 1'b0;
    localparam logic ACTION_READ = 1'b1;

    // Character codes
    localparam logic [CHAR_W-1:0] CODE_NUL       = 8'h00;
    localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CODE_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] SPACE_CODE     = 8'h20;

    // Commands from controller to datapath
    typedef struct packed {
        logic put_en;     // apply a put word to cursor and store
        logic read_en;    // launch a store read
        logic read_load;  // load read data into the output register
        logic clear_en;   // write one space during the clear sweep
    } tcw_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic wrap_clear;  // current put leaves the last row
        logic clear_done;  // sweep is at the last cell
        logic out_free;    // output register can take a result this cycle
    } tcw_sts_t;

endpackage

>>> src/text_console_writer.sv
// Top level of the text console writer: stream ports, controller and datapath.
// Character store and cursor of a COLUMNS x ROWS text console (80 x 25 by default).
// Each input word is a put (write a character at the cursor and advance it; newline,
// tab and backspace move the cursor) or a read of one cell; each gives one result word
// with the cursor after the word and, for a read, the cell's code. A put is handled in
// the idle state, while a read passes through a read-wait state, because the character
// store has a registered read. After reset, and after any put that leaves the last row,
// the block sweeps the store to spaces one cell per cycle and takes no input until the
// sweep has reached the last cell. Results wait in an output register; input is taken
// while that register is empty or being emptied.
module text_console_writer #(
    parameter int COLUMNS  = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS     = tcw_pkg::DEF_ROWS,
    parameter int TAB_STEP = tcw_pkg::DEF_TAB_STEP
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // char_code [7:0], cell_index [18:8], zero [23:19]
    input  logic [tcw_pkg::S_DATA_W-1:0]  s_tdata,
    // action [0]
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // cursor_column [6:0], cursor_row [11:7], read_char [19:12], zero [23:20]
    output logic [tcw_pkg::M_DATA_W-1:0]  m_tdata
);
    import tcw_pkg::*;

    tcw_cmd_t             cmd;
    tcw_sts_t             sts;
    logic                 action;
    logic [CHAR_W-1:0]    char_code;
    logic [INDEX_W-1:0]   cell_index;
    logic [OUT_COL_W-1:0] cursor_column;
    logic [OUT_ROW_W-1:0] cursor_row;
    logic [CHAR_W-1:0]    read_char;

    // Unpack the input word
    assign action     = s_tuser;
    assign char_code  = s_tdata[7:0];
    assign cell_index = s_tdata[18:8];

    tcw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .action   (action),
        .sts      (sts),
        .cmd      (cmd)
    );

    tcw_datapath #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STEP (TAB_STEP)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .char_code     (char_code),
        .cell_index    (cell_index),
        .cmd           (cmd),
        .sts           (sts),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .cursor_column (cursor_column),
        .cursor_row    (cursor_row),
        .read_char     (read_char)
    );

    // Pack the result word
    assign m_tdata = {4'b0000, read_char, cursor_row, cursor_column};

endmodule

>>> src/tcw_ctrl.sv
// Controller state machine of the console writer: accept, read wait and clear sweep.
`include "assert_macros.svh"
module tcw_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              action,
    input  tcw_pkg::tcw_sts_t sts,
    output tcw_pkg::tcw_cmd_t cmd
);
    import tcw_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_CLEAR = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    // Take a word only when idle and the result slot is free
    assign s_tready = (state_reg == ST_IDLE) && sts.out_free;
    assign accept   = s_tvalid && s_tready;

    // Decode commands
    always_comb begin
        cmd           = '0;
        cmd.put_en    = accept && (action == ACTION_PUT);
        cmd.read_en   = accept && (action == ACTION_READ);
        cmd.read_load = (state_reg == ST_READ);
        cmd.clear_en  = (state_reg == ST_CLEAR);
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.read_en) begin
                    state_next = ST_READ;
                end else if (cmd.put_en && sts.wrap_clear) begin
                    state_next = ST_CLEAR;
                end
            end
            ST_READ: begin
                state_next = ST_IDLE;
            end
            ST_CLEAR: begin
                if (sts.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register; reset starts with a sweep of the store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    `TCW_ASSERT_NEXT(a_read_loads, aclk, aresetn, cmd.read_en, cmd.read_load)
    `TCW_ASSERT_NEXT(a_overflow_sweeps, aclk, aresetn,
        cmd.put_en && sts.wrap_clear, cmd.clear_en)

endmodule

>>> src/tcw_datapath.sv
// Datapath of the console writer: cursor registers, character store, sweep counter, result register.
`include "assert_macros.svh"
module tcw_datapath #(
    parameter int COLUMNS  = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS     = tcw_pkg::DEF_ROWS,
    parameter int TAB_STEP = tcw_pkg::DEF_TAB_STEP
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [tcw_pkg::CHAR_W-1:0]      char_code,
    input  logic [tcw_pkg::INDEX_W-1:0]     cell_index,
    input  tcw_pkg::tcw_cmd_t               cmd,
    output tcw_pkg::tcw_sts_t               sts,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [tcw_pkg::OUT_COL_W-1:0]   cursor_column,
    output logic [tcw_pkg::OUT_ROW_W-1:0]   cursor_row,
    output logic [tcw_pkg::CHAR_W-1:0]      read_char
);
    import tcw_pkg::*;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CCOL_W = $clog2(COLUMNS);
    localparam int CROW_W = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS + TAB_STEP);
    localparam int RS_W   = $clog2(ROWS + 1);
    localparam int EXT_W  = (ADDR_W > INDEX_W) ? ADDR_W : INDEX_W;

    logic [CHAR_W-1:0] mem [CELLS];

    logic [CCOL_W-1:0] cur_col_reg;
    logic [CROW_W-1:0] cur_row_reg;
    logic [ADDR_W-1:0] clear_cnt_reg;
    logic [CHAR_W-1:0] rd_data_reg;
    logic              rd_ok_reg;
    logic              m_valid_reg;
    logic [OUT_COL_W-1:0] out_col_reg;
    logic [OUT_ROW_W-1:0] out_row_reg;
    logic [CHAR_W-1:0]    out_char_reg;

    logic [COL_W-1:0]  col_calc;
    logic [RS_W-1:0]   row_calc;
    logic [CCOL_W-1:0] wr_col;
    logic [CHAR_W-1:0] wr_char;
    logic              do_write;
    logic              wrap_clear;
    logic [CCOL_W-1:0] col_next;
    logic [CROW_W-1:0] row_next;
    logic [ADDR_W-1:0] wr_addr;
    logic [EXT_W-1:0]  idx_ext;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_in_range;

    // Cursor motion and cell write of a put word
    always_comb begin
        col_calc = COL_W'(cur_col_reg);
        row_calc = RS_W'(cur_row_reg);
        wr_col   = cur_col_reg;
        wr_char  = char_code;
        do_write = 1'b0;
        case (char_code)
            CODE_NUL: begin
            end
            CODE_NEWLINE: begin
                col_calc = '0;
                row_calc = row_calc + RS_W'(1);
            end
            CODE_TAB: begin
                col_calc = col_calc + COL_W'(TAB_STEP);
            end
            CODE_BACKSPACE: begin
                if (cur_col_reg != '0) begin
                    col_calc = col_calc - COL_W'(1);
                    wr_col   = cur_col_reg - CCOL_W'(1);
                    wr_char  = SPACE_CODE;
                    do_write = 1'b1;
                end
            end
            default: begin
                col_calc = col_calc + COL_W'(1);
                do_write = 1'b1;
            end
        endcase
        // Wrap past the last column
        if (col_calc >= COL_W'(COLUMNS)) begin
            col_calc = '0;
            row_calc = row_calc + RS_W'(1);
        end
        // Leaving the last row homes the cursor
        wrap_clear = (row_calc >= RS_W'(ROWS));
        col_next   = wrap_clear ? '0 : CCOL_W'(col_calc);
        row_next   = wrap_clear ? '0 : CROW_W'(row_calc);
    end

    assign wr_addr     = ADDR_W'(cur_row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(wr_col);
    assign idx_ext     = EXT_W'(cell_index);
    assign rd_addr     = idx_ext[ADDR_W-1:0];
    assign rd_in_range = (idx_ext < EXT_W'(CELLS));

    // Status back to the controller
    always_comb begin
        sts            = '0;
        sts.wrap_clear = wrap_clear;
        sts.clear_done = (clear_cnt_reg == ADDR_W'(CELLS - 1));
        sts.out_free   = !m_valid_reg || m_tready;
    end

    // Character store: one write port shared by sweep and put, one registered read
    always_ff @(posedge aclk) begin
        if (cmd.clear_en) begin
            mem[clear_cnt_reg] <= SPACE_CODE;
        end else if (cmd.put_en && do_write) begin
            mem[wr_addr] <= wr_char;
        end
        if (cmd.read_en) begin
            rd_data_reg <= mem[rd_addr];
            rd_ok_reg   <= rd_in_range;
        end
    end

    // Cursor and sweep counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            clear_cnt_reg <= '0;
        end else begin
            if (cmd.put_en) begin
                cur_col_reg <= col_next;
                cur_row_reg <= row_next;
            end
            if (cmd.clear_en) begin
                clear_cnt_reg <= sts.clear_done ? '0 : clear_cnt_reg + ADDR_W'(1);
            end
        end
    end

    // Result register: hold until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.put_en || cmd.read_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.put_en) begin
            out_col_reg  <= OUT_COL_W'(col_next);
            out_row_reg  <= OUT_ROW_W'(row_next);
            out_char_reg <= '0;
        end else if (cmd.read_load) begin
            out_col_reg  <= OUT_COL_W'(cur_col_reg);
            out_row_reg  <= OUT_ROW_W'(cur_row_reg);
            out_char_reg <= rd_ok_reg ? rd_data_reg : '0;
        end
    end

    assign m_tvalid      = m_valid_reg;
    assign cursor_column = out_col_reg;
    assign cursor_row    = out_row_reg;
    assign read_char     = out_char_reg;

    `TCW_ASSERT_IMPL(a_sweep_exclusive, aclk, aresetn, cmd.clear_en,
        !cmd.put_en && !cmd.read_en)
    `TCW_ASSERT_NEXT(a_overflow_homes, aclk, aresetn, cmd.put_en && wrap_clear,
        cur_col_reg == '0 && cur_row_reg == '0)

endmodule

>>> test/tb_text_console_writer.sv
// Self-checking testbench for the text console writer: directed and random put/read words.
module tb_text_console_writer;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int COLS       = DEF_COLUMNS;
    localparam int ROWS_N     = DEF_ROWS;
    localparam int TAB        = DEF_TAB_STEP;
    localparam int CELLS      = COLS * ROWS_N;
    localparam int IDX_MAX    = (1 << INDEX_W) - 1;
    localparam int PAD_W      = S_DATA_W - CHAR_W - INDEX_W;
    // A full clear sweep plus the longest receiver stall, taken several times over
    localparam int IDLE_LIMIT = 12000;
    localparam int TAIL_CYCLES = 16;
    localparam int REPORT_MAX = 10;

    // One result word, last field in the lowest bits
    typedef struct packed {
        logic [CHAR_W-1:0]    read_char;
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
    } cursor_report_t;

    localparam int REPORT_W = $bits(cursor_report_t);

    typedef enum logic [1:0] {
        RX_STREAM,
        RX_RANDOM,
        RX_PERIODIC,
        RX_BURSTY
    } rx_mode_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [S_DATA_W-1:0]  s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tready = 1'b0;
    wire                  s_tready;
    wire                  m_tvalid;
    wire  [M_DATA_W-1:0]  m_tdata;

    // Shadow copy of the console state
    logic [CHAR_W-1:0]    shadow_screen [CELLS];
    int                   shadow_col;
    int                   shadow_row;

    cursor_report_t       expected_reports [$];
    int                   failures;
    int                   burst_left;
    int                   idle_cycles;

    rx_mode_t             rx_mode = RX_STREAM;
    int                   rx_mode_left = 0;
    int                   rx_stall_left = 0;
    int                   rx_tick = 0;

    text_console_writer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Blank the shadow store
    task automatic clear_shadow();
        for (int i = 0; i < CELLS; i++) shadow_screen[i] = SPACE_CODE;
    endtask

    // Apply one accepted word to the shadow state and form its report
    task automatic apply_console_word(input logic act, input logic [CHAR_W-1:0] code,
                                      input logic [INDEX_W-1:0] idx,
                                      output cursor_report_t rep);
        logic [CHAR_W-1:0] rd;
        rd = '0;
        if (act == ACTION_PUT) begin
            case (code)
                CODE_NUL: begin
                end
                CODE_NEWLINE: begin
                    shadow_row++;
                    shadow_col = 0;
                end
                CODE_TAB: shadow_col += TAB;
                CODE_BACKSPACE: begin
                    if (shadow_col > 0) begin
                        shadow_col--;
                        shadow_screen[shadow_row * COLS + shadow_col] = SPACE_CODE;
                    end
                end
                default: begin
                    shadow_screen[shadow_row * COLS + shadow_col] = code;
                    shadow_col++;
                end
            endcase
            // Wrap past the last column, clear when leaving the last row
            if (shadow_col >= COLS) begin
                shadow_row++;
                shadow_col = 0;
            end
            if (shadow_row >= ROWS_N) begin
                clear_shadow();
                shadow_row = 0;
                shadow_col = 0;
            end
        end else if (idx < CELLS) begin
            rd = shadow_screen[idx];
        end
        rep.col       = shadow_col[OUT_COL_W-1:0];
        rep.row       = shadow_row[OUT_ROW_W-1:0];
        rep.read_char = rd;
    endtask

    // Insert random gaps between bursts of words
    task automatic pace_sender();
        int gap;
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 48);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
    endtask

    // Offer one word and hold it until accepted
    task automatic send_word(input logic act, input logic [CHAR_W-1:0] code,
                             input logic [INDEX_W-1:0] idx);
        cursor_report_t rep;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{PAD_W{1'b0}}, idx, code};
        do @(posedge aclk); while (!s_tready);
        apply_console_word(act, code, idx, rep);
        expected_reports.push_back(rep);
        pace_sender();
    endtask

    task automatic put_char(input logic [CHAR_W-1:0] code);
        send_word(ACTION_PUT, code, INDEX_W'($urandom_range(0, IDX_MAX)));
    endtask

    task automatic read_cell(input int idx);
        send_word(ACTION_READ, CHAR_W'($urandom_range(0, 255)), INDEX_W'(idx));
    endtask

    // Drop valid and hold off until every report has arrived
    task automatic drain_reports();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge aclk);
    endtask

    // Mostly printable text, with control codes and odd bytes mixed in
    function automatic logic [CHAR_W-1:0] random_put_code();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 76) return CHAR_W'($urandom_range(8'h20, 8'h7E));
        if (pick < 84) return CODE_NEWLINE;
        if (pick < 89) return CODE_TAB;
        if (pick < 95) return CODE_BACKSPACE;
        if (pick < 97) return CODE_NUL;
        return CHAR_W'($urandom_range(8'h80, 8'hFF));
    endfunction

    // Cell at or shortly behind the cursor
    function automatic int recent_cell();
        int idx;
        idx = shadow_row * COLS + shadow_col - $urandom_range(0, 24);
        return (idx < 0) ? 0 : idx;
    endfunction

    task automatic test_power_on_store();
        read_cell(0);
        read_cell(CELLS - 1);
        read_cell(CELLS);
        read_cell(IDX_MAX);
    endtask

    task automatic test_put_characters();
        put_char(8'h41);
        put_char(8'hFF);
        put_char(8'h01);
        read_cell(0);
        read_cell(1);
        read_cell(2);
    endtask

    task automatic test_cursor_controls();
        put_char(CODE_BACKSPACE);
        read_cell(2);
        put_char(CODE_NUL);
        put_char(CODE_TAB);
        put_char(CODE_NEWLINE);
        // Backspace at the left edge leaves everything alone
        put_char(CODE_BACKSPACE);
        read_cell(0);
        read_cell(COLS);
    endtask

    // Tab run to the right edge, then wrap and scroll off the bottom
    task automatic test_wrap_and_scroll();
        repeat (COLS / TAB - 1) put_char(CODE_TAB);
        while (shadow_col < COLS - 1) put_char(CHAR_W'($urandom_range(8'h21, 8'h7E)));
        put_char(CHAR_W'($urandom_range(8'h21, 8'h7E)));
        read_cell(recent_cell());
        put_char(CODE_NEWLINE);
        while (shadow_row < COLS - 1 && shadow_row < ROWS_N - 1) begin
            put_char(CODE_NEWLINE);
            if ($urandom_range(0, 3) == 0) read_cell(recent_cell());
        end
        // Tab off the end of the last row clears the screen
        repeat (COLS / TAB) put_char(CODE_TAB);
        read_cell(0);
        read_cell(CELLS - 1);
    endtask

    task automatic test_text_traffic(input int words);
        for (int i = 0; i < words; i++) begin
            case ($urandom_range(0, 9))
                0: read_cell(recent_cell());
                1: read_cell($urandom_range(0, IDX_MAX));
                default: put_char(random_put_code());
            endcase
        end
    endtask

    task automatic test_scroll_storm(input int runs);
        for (int r = 0; r < runs; r++) begin
            while (!(shadow_row == 0 && shadow_col == 0 && $urandom_range(0, 1) == 0)) begin
                if ($urandom_range(0, 2) == 0) put_char(CHAR_W'($urandom_range(8'h20, 8'h7E)));
                else put_char(CODE_NEWLINE);
                if ($urandom_range(0, 5) == 0) read_cell(recent_cell());
            end
            read_cell($urandom_range(0, CELLS - 1));
        end
    endtask

    task automatic test_read_back(input int words);
        drain_reports();
        for (int i = 0; i < words; i++) read_cell($urandom_range(0, IDX_MAX));
    endtask

    task automatic test_noise(input int words);
        for (int i = 0; i < words; i++)
            send_word(logic'($urandom_range(0, 1)), CHAR_W'($urandom_range(0, 255)),
                      INDEX_W'($urandom_range(0, IDX_MAX)));
    endtask

    // Receiver stall pattern, with the style chosen at random anew after each run
    always @(negedge aclk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = rx_mode_t'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(64, 256);
        end
        rx_mode_left--;
        rx_tick++;
        case (rx_mode)
            RX_STREAM:   m_tready <= 1'b1;
            RX_RANDOM:   m_tready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: m_tready <= (rx_tick % 4 == 0);
            RX_BURSTY: begin
                if (rx_stall_left > 0) begin
                    rx_stall_left--;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 15) == 0) rx_stall_left = $urandom_range(1, 12);
                end
            end
        endcase
    end

    // Compare each result word with the oldest expected report
    always @(posedge aclk) begin
        cursor_report_t want;
        cursor_report_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = cursor_report_t'(m_tdata[REPORT_W-1:0]);
            if (expected_reports.size() == 0) begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("%0t: result word with nothing expected: col %0d row %0d char %h",
                             $realtime, got.col, got.row, got.read_char);
            end else begin
                want = expected_reports.pop_front();
                if (got.col != want.col || got.row != want.row
                        || got.read_char != want.read_char) begin
                    failures++;
                    if (failures <= REPORT_MAX)
                        $display("%0t: expected col %0d row %0d ch %h, got col %0d row %0d ch %h",
                                 $realtime, want.col, want.row, want.read_char,
                                 got.col, got.row, got.read_char);
                end
            end
        end
    end

    // End the run if no word moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no word accepted for %0d cycles", IDLE_LIMIT);
                $display("text_console_writer regression: fail");
                $finish;
            end
        end
    end

    initial begin
        failures    = 0;
        idle_cycles = 0;
        burst_left  = $urandom_range(1, 48);
        clear_shadow();
        shadow_col = 0;
        shadow_row = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_power_on_store();
        test_put_characters();
        test_cursor_controls();
        test_wrap_and_scroll();
        test_text_traffic(1000);
        test_scroll_storm(3);
        test_read_back(120);
        test_noise(150);

        drain_reports();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (failures == 0) begin
            $display("text_console_writer regression: pass");
        end else begin
            $display("text_console_writer regression: fail");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/tcw_pkg.sv
src/tcw_ctrl.sv
src/tcw_datapath.sv
src/text_console_writer.sv
test/tb_text_console_writer.sv
